// ----- hw/rtl/bdq_pkg.sv -----
package bdq_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int OP_WIDTH       = 3;
  localparam int STATUS_WIDTH   = 2;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_PUSH    = 3'd0,
    OP_ENQUEUE = 3'd1,
    OP_POP     = 3'd2,
    OP_DEQUEUE = 3'd3,
    OP_REVERSE = 3'd4,
    OP_CLEAR   = 3'd5
  } op_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic write_high;
  } cell_cmd_t;

endpackage

// ----- hw/rtl/bdq_in_if.sv -----
interface bdq_in_if #(
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
);
  logic                             valid;
  logic                             ready;
  logic [bdq_pkg::OP_WIDTH-1:0]     operation;
  logic [DATA_WIDTH-1:0]            data_in;

  modport source (output valid, output operation, output data_in, input ready);
  modport sink (input valid, input operation, input data_in, output ready);
endinterface

// ----- hw/rtl/bdq_out_if.sv -----
interface bdq_out_if #(
  parameter int DATA_WIDTH  = bdq_pkg::DATA_WIDTH_DEF,
  parameter int COUNT_WIDTH = $clog2(bdq_pkg::DEPTH_DEF + 1)
);
  logic                             valid;
  logic                             ready;
  logic [DATA_WIDTH-1:0]            data_out;
  logic [bdq_pkg::STATUS_WIDTH-1:0] status;
  logic [COUNT_WIDTH-1:0]           fill_count;

  modport source (output valid, output data_out, output status, output fill_count, input ready);
  modport sink (input valid, input data_out, input status, input fill_count, output ready);
endinterface

// ----- hw/rtl/bdq_cell.sv -----
module bdq_cell #(
  parameter int DATA_WIDTH  = bdq_pkg::DATA_WIDTH_DEF,
  parameter int COUNT_WIDTH = $clog2(bdq_pkg::DEPTH_DEF + 1),
  parameter int IDX         = 0
) (
  input  logic                  clk,
  input  bdq_pkg::cell_cmd_t    cmd,
  input  logic [COUNT_WIDTH-1:0] count,
  input  logic [DATA_WIDTH-1:0] din,
  input  logic [DATA_WIDTH-1:0] lower_data,
  input  logic [DATA_WIDTH-1:0] upper_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] sel_data
);
  import bdq_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.shift_up) begin
      data_nxt = lower_data;
    end else if (cmd.shift_down) begin
      data_nxt = upper_data;
    end else if (cmd.write_high && (count == COUNT_WIDTH'(IDX))) begin
      data_nxt = din;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data     = data_r;
  assign sel_data = (count == COUNT_WIDTH'(IDX + 1)) ? data_r : '0;

endmodule

// ----- hw/rtl/bounded_deque_with_reverse.sv -----
// Bounded double-ended queue built as a row of word cells that hold the entries in
// logical order from cell zero upward. Every beat is answered by exactly one result
// beat in the cycle after it is taken, and a new beat is taken in every cycle when the
// result register is empty or being drained, so the block sustains one operation per
// cycle. Inserting or removing at the cell-zero end shifts the whole row by one cell;
// the other end is written or read at the cell selected by the fill count. Reverse only
// flips which physical end is the logical top. The fill count in each result is the
// number of entries held after that operation.
module bounded_deque_with_reverse #(
  parameter int DEPTH       = bdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH  = bdq_pkg::DATA_WIDTH_DEF,
  parameter int COUNT_WIDTH = $clog2(DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  bdq_in_if.sink         in_if,
  bdq_out_if.source      out_if
);
  import bdq_pkg::*;

  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [DATA_WIDTH-1:0]  data_out_r;
  logic [DATA_WIDTH-1:0]  data_out_nxt;
  status_t                status_r;
  status_t                status_nxt;
  logic [COUNT_WIDTH-1:0] count_r;
  logic [COUNT_WIDTH-1:0] count_nxt;
  logic                   rev_r;
  logic                   rev_nxt;

  logic                   accept;
  logic                   at_low;
  logic                   is_full;
  logic                   is_empty;
  cell_cmd_t              cmd;
  logic [DATA_WIDTH-1:0]  hi_data;

  logic [DATA_WIDTH-1:0]  cell_data [DEPTH];
  logic [DATA_WIDTH-1:0]  cell_sel [DEPTH];

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign is_full     = (count_r == COUNT_WIDTH'(DEPTH));
  assign is_empty    = (count_r == '0);

  always_comb begin
    hi_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hi_data = hi_data | cell_sel[i];
    end
  end

  always_comb begin
    cmd           = '0;
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    data_out_nxt  = data_out_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    at_low        = 1'b0;
    if (accept) begin
      out_valid_nxt = 1'b1;
      data_out_nxt  = '0;
      status_nxt    = ST_OK;
      case (in_if.operation)
        OP_PUSH, OP_ENQUEUE: begin
          at_low = (in_if.operation == OP_PUSH) ? !rev_r : rev_r;
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.shift_up   = at_low;
            cmd.write_high = !at_low;
            count_nxt      = count_r + COUNT_WIDTH'(1);
          end
        end
        OP_POP, OP_DEQUEUE: begin
          at_low = (in_if.operation == OP_POP) ? !rev_r : rev_r;
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            cmd.shift_down = at_low;
            data_out_nxt   = at_low ? cell_data[0] : hi_data;
            count_nxt      = count_r - COUNT_WIDTH'(1);
          end
        end
        OP_REVERSE: begin
          rev_nxt = !rev_r;
        end
        OP_CLEAR: begin
          count_nxt = '0;
          rev_nxt   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
      rev_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_out_r <= data_out_nxt;
    status_r   <= status_nxt;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower;
    logic [DATA_WIDTH-1:0] upper;

    if (g == 0) begin : g_first
      assign lower = in_if.data_in;
    end else begin : g_mid
      assign lower = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign upper = cell_data[g];
    end else begin : g_up
      assign upper = cell_data[g+1];
    end

    bdq_cell #(
      .DATA_WIDTH  (DATA_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH),
      .IDX         (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count_r),
      .din        (in_if.data_in),
      .lower_data (lower),
      .upper_data (upper),
      .data       (cell_data[g]),
      .sel_data   (cell_sel[g])
    );
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.data_out   = data_out_r;
  assign out_if.status     = status_r;
  assign out_if.fill_count = count_r;

endmodule

// ----- hw/rtl/bdq_chk.sv -----
module bdq_chk #(
  parameter int DEPTH       = bdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH  = bdq_pkg::DATA_WIDTH_DEF,
  parameter int COUNT_WIDTH = $clog2(DEPTH + 1)
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [bdq_pkg::OP_WIDTH-1:0]     in_operation,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [DATA_WIDTH-1:0]            out_data_out,
  input logic [bdq_pkg::STATUS_WIDTH-1:0] out_status,
  input logic [COUNT_WIDTH-1:0]           out_fill_count
);
  import bdq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fill_count <= COUNT_WIDTH'(DEPTH))
    else $error("fill count beyond depth");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && rst_n && (in_operation == OP_CLEAR)
    |=> out_valid && (out_fill_count == '0) && (out_status == ST_OK))
    else $error("clear did not empty the deque");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_data_out == '0) && (out_fill_count == '0))
    else $error("empty removal returned data or a nonzero count");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_fill_count == COUNT_WIDTH'(DEPTH))
    else $error("full status with room left");

endmodule

bind bounded_deque_with_reverse bdq_chk #(
  .DEPTH       (DEPTH),
  .DATA_WIDTH  (DATA_WIDTH),
  .COUNT_WIDTH (COUNT_WIDTH)
) u_bdq_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .in_operation   (in_if.operation),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_data_out   (out_if.data_out),
  .out_status     (out_if.status),
  .out_fill_count (out_if.fill_count)
);

// ----- tb/bounded_deque_with_reverse_tb.sv -----
module bounded_deque_with_reverse_tb;
  import bdq_pkg::*;

  localparam int SLOTS = DEPTH_DEF;
  localparam int POS_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [OP_WIDTH-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_WIDTH-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [DATA_WIDTH_DEF-1:0] word;
    status_t                   st;
    logic [CNT_W-1:0]          count;
  } deque_result_t;

  logic clk;
  logic rst_n;

  bdq_in_if  in_ch();
  bdq_out_if out_ch();

  bounded_deque_with_reverse dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Shadow copy of the deque contents and pointers.
  logic [DATA_WIDTH_DEF-1:0] shadow_words [SLOTS];
  logic [POS_W-1:0]          low_end;
  logic [POS_W-1:0]          high_end;
  logic [CNT_W-1:0]          held;
  logic                      flipped;

  deque_result_t pending_results [$];
  int mismatch_count = 0;
  int burst_left = 0;
  int beats_by_op [8];
  int full_drops = 0;
  int empty_removals = 0;
  int peak_fill = 0;
  int results_seen = 0;
  logic [15:0] stall_tick = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic deque_result_t apply_deque_op(logic [OP_WIDTH-1:0] op,
                                                   logic [DATA_WIDTH_DEF-1:0] word);
    deque_result_t r;
    logic at_low;
    r.word = '0;
    r.st   = ST_OK;
    case (op)
      OP_PUSH, OP_ENQUEUE: begin
        at_low = (op == OP_PUSH) ? !flipped : flipped;
        if (held == CNT_W'(SLOTS)) begin
          r.st = ST_FULL;
        end else begin
          if (held == '0) begin
            high_end = low_end;
          end else if (at_low) begin
            low_end = low_end - POS_W'(1);
          end else begin
            high_end = high_end + POS_W'(1);
          end
          shadow_words[at_low ? low_end : high_end] = word;
          held = held + CNT_W'(1);
        end
      end
      OP_POP, OP_DEQUEUE: begin
        at_low = (op == OP_POP) ? !flipped : flipped;
        if (held == '0) begin
          r.st = ST_EMPTY;
        end else begin
          if (at_low) begin
            r.word = shadow_words[low_end];
            if (held > CNT_W'(1)) low_end = low_end + POS_W'(1);
          end else begin
            r.word = shadow_words[high_end];
            if (held > CNT_W'(1)) high_end = high_end - POS_W'(1);
          end
          held = held - CNT_W'(1);
        end
      end
      OP_REVERSE: flipped = !flipped;
      OP_CLEAR: begin
        held     = '0;
        low_end  = '0;
        high_end = '0;
        flipped  = 1'b0;
      end
      default: ;
    endcase
    r.count = held;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_WIDTH_DEF-1:0] want,
                                 logic [DATA_WIDTH_DEF-1:0] seen);
    $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, seen, $realtime);
    mismatch_count++;
  endtask

  // Input beats are predicted before output beats are checked on the same edge.
  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      want = apply_deque_op(in_ch.operation, in_ch.data_in);
      beats_by_op[in_ch.operation]++;
      if (want.st == ST_FULL) full_drops++;
      if (want.st == ST_EMPTY) empty_removals++;
      if (int'(want.count) > peak_fill) peak_fill = int'(want.count);
      pending_results.push_back(want);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing outstanding", '0, out_ch.data_out);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.data_out !== want.word)
          report_mismatch("data_out", want.word, out_ch.data_out);
        if (out_ch.status !== want.st)
          report_mismatch("status", DATA_WIDTH_DEF'(want.st), DATA_WIDTH_DEF'(out_ch.status));
        if (out_ch.fill_count !== want.count)
          report_mismatch("fill_count", DATA_WIDTH_DEF'(want.count),
                          DATA_WIDTH_DEF'(out_ch.fill_count));
      end
    end
  end

  // The receiver cycles through always-ready, random, periodic and burst stall patterns.
  always @(negedge clk) begin
    stall_tick <= stall_tick + 16'd1;
    case (stall_tick[9:8])
      2'd0: out_ch.ready <= 1'b1;
      2'd1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2'd2: out_ch.ready <= (stall_tick % 3 == 0);
      default: out_ch.ready <= (stall_tick[3:0] < 4'd10);
    endcase
  end

  task automatic send_beat(logic [OP_WIDTH-1:0] op, logic [DATA_WIDTH_DEF-1:0] word);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 10);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.data_in   <= word;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [DATA_WIDTH_DEF-1:0] pick_word();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [OP_WIDTH-1:0] pick_op(bit grow);
    int r;
    r = $urandom_range(0, 99);
    if (grow) begin
      if (r < 28) return OP_PUSH;
      if (r < 56) return OP_ENQUEUE;
      if (r < 70) return OP_POP;
      if (r < 84) return OP_DEQUEUE;
    end else begin
      if (r < 14) return OP_PUSH;
      if (r < 28) return OP_ENQUEUE;
      if (r < 56) return OP_POP;
      if (r < 84) return OP_DEQUEUE;
    end
    if (r < 94) return OP_REVERSE;
    if (r < 96) return OP_CLEAR;
    if (r < 98) return OP_SPARE_6;
    return OP_SPARE_7;
  endfunction

  task automatic test_directed_ends();
    send_beat(OP_POP, 32'h1234_5678);
    send_beat(OP_DEQUEUE, 32'h8765_4321);
    send_beat(OP_REVERSE, '0);
    send_beat(OP_REVERSE, '1);
    send_beat(OP_PUSH, '0);
    send_beat(OP_PUSH, '1);
    send_beat(OP_ENQUEUE, 32'h0000_0001);
    send_beat(OP_ENQUEUE, 32'h8000_0000);
    send_beat(OP_POP, '0);
    send_beat(OP_DEQUEUE, '0);
    send_beat(OP_REVERSE, '0);
    send_beat(OP_POP, '0);
    send_beat(OP_PUSH, 32'hA5A5_A5A5);
    send_beat(OP_ENQUEUE, 32'h5A5A_5A5A);
    send_beat(OP_DEQUEUE, '0);
    send_beat(OP_SPARE_6, $urandom);
    send_beat(OP_SPARE_7, $urandom);
    send_beat(OP_CLEAR, '1);
    send_beat(OP_POP, '0);
    send_beat(OP_ENQUEUE, 32'hDEAD_BEEF);
    send_beat(OP_DEQUEUE, '0);
    send_beat(OP_DEQUEUE, '0);
    wait_until_drained();
  endtask

  task automatic test_full_boundary();
    repeat (SLOTS) send_beat($urandom_range(0, 1) ? OP_PUSH : OP_ENQUEUE, pick_word());
    send_beat(OP_PUSH, '1);
    send_beat(OP_ENQUEUE, '1);
    send_beat(OP_REVERSE, '0);
    send_beat(OP_PUSH, $urandom);
    repeat (SLOTS) send_beat($urandom_range(0, 1) ? OP_POP : OP_DEQUEUE, '0);
    send_beat(OP_POP, '0);
    send_beat(OP_DEQUEUE, '0);
  endtask

  task automatic test_random_mix(int beats);
    int seg;
    bit grow;
    while (beats > 0) begin
      seg  = $urandom_range(40, 200);
      grow = $urandom_range(0, 1);
      if (seg > beats) seg = beats;
      repeat (seg) send_beat(pick_op(grow), pick_word());
      beats -= seg;
    end
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_PUSH;
    in_ch.data_in   = '0;
    out_ch.ready    = 1'b0;
    rst_n           = 1'b0;
    held            = '0;
    low_end         = '0;
    high_end        = '0;
    flipped         = 1'b0;
    foreach (beats_by_op[i]) beats_by_op[i] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_ends();
    test_full_boundary();
    test_random_mix(700);
    wait_until_drained();
    test_random_mix(680);
    wait_until_drained();
    repeat (10) @(posedge clk);

    $display("Covered %0d results: push %0d, enqueue %0d, pop %0d, dequeue %0d, reverse %0d,",
             results_seen, beats_by_op[OP_PUSH], beats_by_op[OP_ENQUEUE],
             beats_by_op[OP_POP], beats_by_op[OP_DEQUEUE], beats_by_op[OP_REVERSE]);
    $display("clear %0d, unused codes %0d; %0d full drops, %0d empty removals, peak fill %0d.",
             beats_by_op[OP_CLEAR], beats_by_op[OP_SPARE_6] + beats_by_op[OP_SPARE_7],
             full_drops, empty_removals, peak_fill);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
